/* src/roulette_wheel_selector_defines.svh */
// Assertion helpers for the roulette wheel selector.
`ifndef ROULETTE_WHEEL_SELECTOR_DEFINES_SVH
`define ROULETTE_WHEEL_SELECTOR_DEFINES_SVH

// Same-cycle implication.
`define RWS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RWS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rws_pkg.sv */
`default_nettype none
package rws_pkg;

  localparam int MAX_POP      = 256;
  localparam int GENOME_BITS  = 17;
  localparam int FITNESS_BITS = 24;
  localparam int IDX_W        = $clog2(MAX_POP);
  localparam int CNT_W        = $clog2(MAX_POP + 1);
  localparam int SUM_W        = 32;
  localparam int ACC_W        = SUM_W + 1;
  localparam int SPIN_W       = 17;
  localparam int FRAC_BITS    = 16;
  localparam int PROD_W       = SPIN_W + SUM_W;
  localparam int ENTRY_W      = GENOME_BITS + FITNESS_BITS;

  localparam logic [SPIN_W-1:0] SPIN_ONE = SPIN_W'(65536);
  localparam logic [CNT_W-1:0]  POP_FULL = CNT_W'(MAX_POP);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_SELECT = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_THRESH,
    S_SCAN,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

/* src/rws_ram.sv */
`default_nettype none
module rws_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 41,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* src/roulette_wheel_selector.sv */
// Roulette wheel selector.
// Input channel (in_valid / in_stall) carries one command per transaction:
// clear, add an individual, or select by roulette spin. Every transaction
// yields exactly one result transaction on the output channel
// (out_valid / out_stall), in order.
// Clear, add and the unused command go straight to the done state. A
// select on a non-empty table first passes the threshold state (the spin
// times total multiply), then the scan state, which reads one stored
// fitness per cycle from the table RAM, newest entry first, until the
// running sum reaches the threshold or the oldest entry is reached. An
// empty select goes straight to the done state. One command is worked on
// at a time; in_stall is high while it is worked on.
// The output register lets the next command be accepted while a result
// waits; if the receiver stalls, a finished result waits in the block and
// in_stall stays high until the output register frees up.
// Synchronous reset empties the table (count and total to zero) and drops
// any pending result. The table RAM itself is not cleared.
`default_nettype none
`include "roulette_wheel_selector_defines.svh"
module roulette_wheel_selector (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [16:0] in_genome,
  input  wire logic [23:0] in_fitness,
  input  wire logic [16:0] in_spin,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [7:0]       out_chosen_index,
  output logic [16:0]      out_chosen_genome,
  output logic [23:0]      out_chosen_fitness,
  output logic [8:0]       out_population,
  output logic [31:0]      out_fitness_sum
);

  localparam int IDX_W = rws_pkg::IDX_W;
  localparam int CNT_W = rws_pkg::CNT_W;
  localparam int SUM_W = rws_pkg::SUM_W;
  localparam int ACC_W = rws_pkg::ACC_W;
  localparam int GB    = rws_pkg::GENOME_BITS;
  localparam int FB    = rws_pkg::FITNESS_BITS;

  rws_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [SUM_W-1:0]         total_r, total_nxt;
  logic [rws_pkg::SPIN_W-1:0] spin_r, spin_nxt;
  logic [SUM_W-1:0]         thresh_r, thresh_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;

  logic [1:0]               res_status_r, res_status_nxt;
  logic [IDX_W-1:0]         res_idx_r, res_idx_nxt;
  logic [GB-1:0]            res_genome_r, res_genome_nxt;
  logic [FB-1:0]            res_fitness_r, res_fitness_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_status_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic [GB-1:0]            out_genome_r;
  logic [FB-1:0]            out_fitness_r;
  logic [CNT_W-1:0]         out_pop_r;
  logic [SUM_W-1:0]         out_sum_r;

  logic                     in_accept;
  logic                     out_free;
  logic                     out_load;
  logic                     hit;
  logic [CNT_W-1:0]         cnt_m1;
  logic [SUM_W:0]           add_sum;
  logic [rws_pkg::PROD_W-1:0] prod;
  logic [ACC_W-1:0]         acc_sum;

  logic                     wr_en;
  logic [IDX_W-1:0]         rd_addr;
  logic [rws_pkg::ENTRY_W-1:0] rd_data;
  logic [GB-1:0]            rd_genome;
  logic [FB-1:0]            rd_fitness;

  rws_ram #(
    .DEPTH (rws_pkg::MAX_POP),
    .WIDTH (rws_pkg::ENTRY_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({in_genome, in_fitness}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_genome  = rd_data[rws_pkg::ENTRY_W-1:FB];
  assign rd_fitness = rd_data[FB-1:0];

  assign in_stall  = (state_r != rws_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == rws_pkg::S_DONE) && out_free;

  assign cnt_m1  = count_r - CNT_W'(1);
  assign add_sum = {1'b0, total_r} + (SUM_W + 1)'(in_fitness);
  assign prod    = rws_pkg::PROD_W'(spin_r) * rws_pkg::PROD_W'(total_r);
  assign acc_sum = acc_r + ACC_W'(rd_fitness);
  assign hit     = (ACC_W'(thresh_r) <= acc_sum) || (idx_r == '0);

  assign wr_en   = in_accept && (in_cmd == rws_pkg::CMD_ADD) && (count_r < rws_pkg::POP_FULL);
  assign rd_addr = (state_r == rws_pkg::S_THRESH) ? cnt_m1[IDX_W-1:0] : idx_r - IDX_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rws_pkg::S_IDLE: begin
        if (in_accept) begin
          if ((in_cmd == rws_pkg::CMD_SELECT) && (count_r != '0)) begin
            state_nxt = rws_pkg::S_THRESH;
          end else begin
            state_nxt = rws_pkg::S_DONE;
          end
        end
      end
      rws_pkg::S_THRESH: state_nxt = rws_pkg::S_SCAN;
      rws_pkg::S_SCAN: begin
        if (hit) begin
          state_nxt = rws_pkg::S_DONE;
        end
      end
      rws_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = rws_pkg::S_IDLE;
        end
      end
      default: state_nxt = rws_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt       = count_r;
    total_nxt       = total_r;
    spin_nxt        = spin_r;
    thresh_nxt      = thresh_r;
    acc_nxt         = acc_r;
    idx_nxt         = idx_r;
    res_status_nxt  = res_status_r;
    res_idx_nxt     = res_idx_r;
    res_genome_nxt  = res_genome_r;
    res_fitness_nxt = res_fitness_r;
    out_valid_nxt   = out_valid_r && out_stall;
    case (state_r)
      rws_pkg::S_IDLE: begin
        if (in_accept) begin
          res_status_nxt  = rws_pkg::ST_OK;
          res_idx_nxt     = '0;
          res_genome_nxt  = '0;
          res_fitness_nxt = '0;
          spin_nxt        = (in_spin > rws_pkg::SPIN_ONE) ? rws_pkg::SPIN_ONE : in_spin;
          case (in_cmd)
            rws_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              total_nxt = '0;
            end
            rws_pkg::CMD_ADD: begin
              if (count_r >= rws_pkg::POP_FULL) begin
                res_status_nxt = rws_pkg::ST_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
                total_nxt = add_sum[SUM_W] ? '1 : add_sum[SUM_W-1:0];
              end
            end
            rws_pkg::CMD_SELECT: begin
              if (count_r == '0) begin
                res_status_nxt = rws_pkg::ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      rws_pkg::S_THRESH: begin
        thresh_nxt = prod[SUM_W+rws_pkg::FRAC_BITS-1:rws_pkg::FRAC_BITS];
        acc_nxt    = '0;
        idx_nxt    = cnt_m1[IDX_W-1:0];
      end
      rws_pkg::S_SCAN: begin
        acc_nxt = acc_sum;
        if (hit) begin
          res_idx_nxt     = idx_r;
          res_genome_nxt  = rd_genome;
          res_fitness_nxt = rd_fitness;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
      rws_pkg::S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rws_pkg::S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    spin_r        <= spin_nxt;
    thresh_r      <= thresh_nxt;
    acc_r         <= acc_nxt;
    idx_r         <= idx_nxt;
    res_status_r  <= res_status_nxt;
    res_idx_r     <= res_idx_nxt;
    res_genome_r  <= res_genome_nxt;
    res_fitness_r <= res_fitness_nxt;
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_idx_r     <= res_idx_r;
      out_genome_r  <= res_genome_r;
      out_fitness_r <= res_fitness_r;
      out_pop_r     <= count_r;
      out_sum_r     <= total_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_chosen_index   = out_idx_r;
  assign out_chosen_genome  = out_genome_r;
  assign out_chosen_fitness = out_fitness_r;
  assign out_population     = out_pop_r;
  assign out_fitness_sum    = out_sum_r;

  `RWS_ASSERT_IMP(a_scan_in_range, state_r == rws_pkg::S_SCAN,
    CNT_W'(idx_r) < count_r, "scan index beyond population")
  `RWS_ASSERT_NXT(a_done_holds, (state_r == rws_pkg::S_DONE) && out_valid_r && out_stall,
    state_r == rws_pkg::S_DONE, "pending result dropped while output stalled")
  `RWS_ASSERT_IMP(a_empty_pop, out_valid_r && (out_status_r == rws_pkg::ST_EMPTY),
    out_pop_r == '0, "empty status with nonzero population")

endmodule
`default_nettype wire

/* tb/sv/tb_roulette_wheel_selector.sv */
`default_nettype none
module tb_roulette_wheel_selector;
  timeunit 1ns;
  timeprecision 1ps;

  import rws_pkg::*;

  localparam int HOLD_AT  = 300;
  localparam int HOLD_LEN = 400;
  localparam int CALM_LO  = 700;
  localparam int CALM_HI  = 1000;
  localparam int WATCHDOG = 4000;
  localparam int TAIL     = 300;
  localparam int N_ITEMS  = 1600;

  typedef struct {
    cmd_t              cmd;
    logic [16:0]       genome;
    logic [23:0]       fitness;
    logic [16:0]       spin;
    bit                drain;
  } wheel_cmd_t;

  typedef struct {
    status_t           status;
    logic [7:0]        index;
    logic [16:0]       genome;
    logic [23:0]       fitness;
    logic [8:0]        population;
    logic [31:0]       total;
  } wheel_outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = 2'd0;
  logic [16:0] in_genome = '0;
  logic [23:0] in_fitness = '0;
  logic [16:0] in_spin = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_chosen_index;
  logic [16:0] out_chosen_genome;
  logic [23:0] out_chosen_fitness;
  logic [8:0]  out_population;
  logic [31:0] out_fitness_sum;

  roulette_wheel_selector dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_genome          (in_genome),
    .in_fitness         (in_fitness),
    .in_spin            (in_spin),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_chosen_index   (out_chosen_index),
    .out_chosen_genome  (out_chosen_genome),
    .out_chosen_fitness (out_chosen_fitness),
    .out_population     (out_population),
    .out_fitness_sum    (out_fitness_sum)
  );

  always #1 clk = ~clk;

  wheel_cmd_t     cmd_q[$];
  wheel_outcome_t outcome_q[$];
  wheel_cmd_t     cur_cmd;

  // population table as the block should hold it
  logic [16:0] pop_genome [MAX_POP];
  logic [23:0] pop_fitness [MAX_POP];
  int          pop_count = 0;
  logic [31:0] pop_total = '0;

  int n_issued = 0;
  int n_returned = 0;
  int errors = 0;
  int gen_count = 0;

  task automatic predict_outcome(input wheel_cmd_t c);
    wheel_outcome_t   r;
    logic [16:0]      spin_sat;
    logic [48:0]      prod;
    logic [32:0]      sum;
    longint unsigned  thresh;
    longint unsigned  acc;
    int               k;
    r.status = ST_OK;
    r.index = '0;
    r.genome = '0;
    r.fitness = '0;
    case (c.cmd)
      CMD_CLEAR: begin
        pop_count = 0;
        pop_total = '0;
      end
      CMD_ADD: begin
        if (pop_count >= MAX_POP) begin
          r.status = ST_FULL;
        end else begin
          pop_genome[pop_count] = c.genome;
          pop_fitness[pop_count] = c.fitness;
          pop_count++;
          sum = {1'b0, pop_total} + 33'(c.fitness);
          pop_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
      end
      CMD_SELECT: begin
        if (pop_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          spin_sat = (c.spin > SPIN_ONE) ? SPIN_ONE : c.spin;
          prod = 49'(spin_sat) * 49'(pop_total);
          thresh = longint'(prod >> FRAC_BITS);
          acc = 0;
          for (k = pop_count - 1; k >= 0; k--) begin
            acc += longint'(pop_fitness[k]);
            r.index = 8'(k);
            r.genome = pop_genome[k];
            r.fitness = pop_fitness[k];
            if (thresh <= acc) break;
          end
        end
      end
      default: ;
    endcase
    r.population = 9'(pop_count);
    r.total = pop_total;
    outcome_q.push_back(r);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch expected 0x%0h actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    bit fire;
    bit drained;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        predict_outcome(cur_cmd);
        n_issued <= n_issued + 1;
      end
      if (!in_valid || fire) begin
        drained = !fire && (n_returned + int'(out_valid && !out_stall) == n_issued);
        if (cmd_q.size() != 0 && (!cmd_q[0].drain || drained) &&
            ((n_issued >= CALM_LO && n_issued < CALM_HI) || $urandom_range(99) >= 28)) begin
          cur_cmd = cmd_q.pop_front();
          in_cmd <= cur_cmd.cmd;
          in_genome <= cur_cmd.genome;
          in_fitness <= cur_cmd.fitness;
          in_spin <= cur_cmd.spin;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_returned >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (n_returned >= CALM_LO && n_returned < CALM_HI) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 28);
    end
  end

  // monitor
  always @(posedge clk) begin
    wheel_outcome_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      n_returned <= n_returned + 1;
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected transaction expected none actual status %0d pop %0d",
                 $time, out_status, out_population);
        errors++;
      end else begin
        exp_r = outcome_q.pop_front();
        check_field("status", exp_r.status, out_status);
        check_field("chosen_index", exp_r.index, out_chosen_index);
        check_field("chosen_genome", exp_r.genome, out_chosen_genome);
        check_field("chosen_fitness", exp_r.fitness, out_chosen_fitness);
        check_field("population", exp_r.population, out_population);
        check_field("fitness_sum", exp_r.total, out_fitness_sum);
      end
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= WATCHDOG) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic add_cmd(input cmd_t c, input logic [16:0] g, input logic [23:0] f,
                         input logic [16:0] s, input bit drain = 1'b0);
    wheel_cmd_t it;
    it.cmd = c;
    it.genome = g;
    it.fitness = f;
    it.spin = s;
    it.drain = drain;
    cmd_q.push_back(it);
    if (c == CMD_CLEAR) gen_count = 0;
    else if (c == CMD_ADD && gen_count < MAX_POP) gen_count++;
  endtask

  function automatic logic [23:0] rand_fitness();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return 24'd0;
    if (roll < 10) return 24'hFF_FFFF;
    if (roll < 30) return 24'($urandom_range(255));
    return 24'($urandom);
  endfunction

  function automatic logic [16:0] rand_spin();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return 17'd0;
    if (roll < 10) return SPIN_ONE;
    if (roll < 16) return 17'($urandom_range(131071, 65537));
    return 17'($urandom_range(65536));
  endfunction

  task automatic fill_table(input bit max_fit);
    int i;
    add_cmd(CMD_CLEAR, 17'($urandom), 24'($urandom), 17'($urandom));
    for (i = 0; i < MAX_POP; i++)
      add_cmd(CMD_ADD, 17'($urandom), max_fit ? 24'hFF_FFFF : rand_fitness(), rand_spin());
    for (i = 0; i < 3; i++)
      add_cmd(CMD_ADD, 17'($urandom), rand_fitness(), rand_spin());
    for (i = 0; i < 6; i++)
      add_cmd(CMD_SELECT, 17'($urandom), 24'($urandom), rand_spin());
    add_cmd(CMD_SELECT, 17'($urandom), 24'($urandom), SPIN_ONE);
    add_cmd(CMD_SELECT, 17'($urandom), 24'($urandom), 17'd0);
  endtask

  initial begin
    int fills;
    int k;
    int m;
    int roll;
    bit drain;

    // directed
    add_cmd(CMD_SELECT, 17'h1FFFF, 24'hFF_FFFF, 17'd0);
    add_cmd(CMD_NOP, 17'h1FFFF, 24'hFF_FFFF, 17'h1FFFF);
    add_cmd(CMD_CLEAR, 17'h0, 24'h0, 17'h0);
    add_cmd(CMD_ADD, 17'h0, 24'h0, 17'h0);
    add_cmd(CMD_SELECT, 17'h0, 24'h0, 17'd0);
    add_cmd(CMD_SELECT, 17'h0, 24'h0, SPIN_ONE);
    add_cmd(CMD_ADD, 17'h1FFFF, 24'hFF_FFFF, 17'h1FFFF);
    add_cmd(CMD_ADD, 17'h0AAAA, 24'h00_0001, 17'h0);
    add_cmd(CMD_ADD, 17'h15555, 24'h80_0000, 17'h0);
    add_cmd(CMD_SELECT, 17'h0, 24'h0, 17'd0);
    add_cmd(CMD_SELECT, 17'h0, 24'h0, SPIN_ONE);
    add_cmd(CMD_SELECT, 17'h0, 24'h0, 17'h1FFFF);
    add_cmd(CMD_SELECT, 17'h0, 24'h0, 17'd65537);
    add_cmd(CMD_SELECT, 17'h0, 24'h0, 17'd32768);
    add_cmd(CMD_SELECT, 17'h0, 24'h0, 17'd49152);
    add_cmd(CMD_NOP, 17'h0, 24'h0, 17'h0);
    add_cmd(CMD_ADD, 17'h0F0F0, 24'h55_5555, 17'h0);
    add_cmd(CMD_SELECT, 17'h0, 24'h0, 17'd1);
    add_cmd(CMD_CLEAR, 17'h1FFFF, 24'hFF_FFFF, 17'h1FFFF);
    add_cmd(CMD_SELECT, 17'h0, 24'h0, SPIN_ONE);
    add_cmd(CMD_ADD, 17'h00001, 24'hAA_AAAA, 17'h0);
    add_cmd(CMD_SELECT, 17'h0, 24'h0, SPIN_ONE);

    // random
    fills = 0;
    drain = 1'b1;
    while (cmd_q.size() < N_ITEMS) begin
      roll = $urandom_range(99);
      if (fills < 2 && cmd_q.size() > 400 * (fills + 1)) begin
        fill_table(fills == 0);
        fills++;
      end else if (roll < 8) begin
        m = $urandom_range(1, 5);
        for (k = 0; k < m; k++)
          add_cmd(cmd_t'($urandom_range(3)), 17'($urandom), rand_fitness(),
                  17'($urandom), drain && k == 0);
      end else begin
        if ($urandom_range(99) < 70 || gen_count > 200)
          add_cmd(CMD_CLEAR, 17'($urandom), 24'($urandom), 17'($urandom), drain);
        else
          add_cmd(CMD_SELECT, 17'($urandom), 24'($urandom), rand_spin(), drain);
        m = $urandom_range(1, 24);
        for (k = 0; k < m; k++)
          add_cmd(CMD_ADD, 17'($urandom), rand_fitness(), 17'($urandom));
        m = $urandom_range(4, 12);
        for (k = 0; k < m; k++) begin
          roll = $urandom_range(99);
          if (roll < 70)
            add_cmd(CMD_SELECT, 17'($urandom), 24'($urandom), rand_spin());
          else if (roll < 90)
            add_cmd(CMD_ADD, 17'($urandom), rand_fitness(), 17'($urandom));
          else
            add_cmd(cmd_t'($urandom_range(3)), 17'($urandom), rand_fitness(),
                    17'($urandom));
        end
      end
      drain = ($urandom_range(99) < 10);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || in_valid || n_returned != n_issued) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (outcome_q.size() != 0) begin
      $display("%0t: %0d transactions expected actual none", $time, outcome_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
+incdir+src
src/rws_pkg.sv
src/rws_ram.sv
src/roulette_wheel_selector.sv
tb/sv/tb_roulette_wheel_selector.sv
